[src/pfc_pkg.sv]
`default_nettype none

package pfc_pkg;

    localparam int TABLE_SIZE_DEF = 131072;
    localparam int VALUE_W        = 17;
    localparam int COUNT_W        = 5;

    // table port control from one requester
    typedef struct packed {
        logic rd;
        logic wr;
    } t_mem_ctl;

    typedef enum logic [2:0] {
        SV_CLEAR,
        SV_INEXT,
        SV_ICHECK,
        SV_JREAD,
        SV_JWRITE,
        SV_DONE
    } t_sieve_state;

    typedef enum logic [1:0] {
        QY_IDLE,
        QY_CHECK,
        QY_DONE
    } t_query_state;

endpackage

`default_nettype wire

[src/pfc_ram.sv]
`default_nettype none

module pfc_ram #(
    parameter int TABLE_SIZE = pfc_pkg::TABLE_SIZE_DEF
) (
    input  wire                               i_clk,
    input  pfc_pkg::t_mem_ctl                 i_ctl,
    input  wire [$clog2(TABLE_SIZE)-1:0]      i_addr,
    input  wire [2*$clog2(TABLE_SIZE)-1:0]    i_wdata,
    output logic [2*$clog2(TABLE_SIZE)-1:0]   o_rdata
);
    import pfc_pkg::*;

    localparam int W = $clog2(TABLE_SIZE);

    logic [2*W-1:0] mem [TABLE_SIZE];

    // single port, write wins, read data registered
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            mem[i_addr] <= i_wdata;
        end else if (i_ctl.rd) begin
            o_rdata <= mem[i_addr];
        end
    end

endmodule

`default_nettype wire

[src/pfc_sieve.sv]
`default_nettype none

module pfc_sieve #(
    parameter int TABLE_SIZE = pfc_pkg::TABLE_SIZE_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire [2*$clog2(TABLE_SIZE)-1:0]    i_rdata,
    output pfc_pkg::t_mem_ctl                 o_ctl,
    output logic [$clog2(TABLE_SIZE)-1:0]     o_addr,
    output logic [2*$clog2(TABLE_SIZE)-1:0]   o_wdata,
    output logic                              o_done
);
    import pfc_pkg::*;

    localparam int W = $clog2(TABLE_SIZE);
    localparam logic [W-1:0]   LAST_ADDR = W'(TABLE_SIZE - 1);
    localparam logic [2*W-1:0] SIZE_SQ   = (2*W)'(TABLE_SIZE);
    localparam logic [W:0]     SIZE_J    = (W+1)'(TABLE_SIZE);

    t_sieve_state r_state, n_state;
    logic [W-1:0]   r_cnt;
    logic [W-1:0]   r_i;
    logic [2*W-1:0] r_sq;
    logic [W-1:0]   r_j;
    logic [W-1:0]   r_k;
    logic [W:0]     j_sum;
    logic           spf_zero;

    assign j_sum    = {1'b0, r_j} + {1'b0, r_i};
    assign spf_zero = (i_rdata[W-1:0] == '0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SV_CLEAR:  if (r_cnt == LAST_ADDR) n_state = SV_INEXT;
            SV_INEXT:  n_state = SV_ICHECK;
            SV_ICHECK: begin
                if (r_sq >= SIZE_SQ) begin
                    n_state = SV_DONE;
                end else if (spf_zero) begin
                    n_state = SV_JREAD;
                end else begin
                    n_state = SV_INEXT;
                end
            end
            SV_JREAD:  n_state = SV_JWRITE;
            SV_JWRITE: n_state = (j_sum >= SIZE_J) ? SV_INEXT : SV_JREAD;
            SV_DONE:   n_state = SV_DONE;
            default:   n_state = SV_CLEAR;
        endcase
    end

    always_comb begin
        o_ctl   = '0;
        o_addr  = r_j;
        o_wdata = {r_k, r_i};
        o_done  = 1'b0;
        unique case (r_state)
            SV_CLEAR: begin
                o_ctl.wr = 1'b1;
                o_addr   = r_cnt;
                o_wdata  = '0;
            end
            SV_INEXT: begin
                o_ctl.rd = 1'b1;
                o_addr   = r_i;
            end
            SV_JREAD:  o_ctl.rd = 1'b1;
            SV_JWRITE: o_ctl.wr = spf_zero;
            SV_DONE:   o_done   = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SV_CLEAR;
            r_cnt   <= '0;
            r_i     <= W'(2);
        end else begin
            r_state <= n_state;
            if (r_state == SV_CLEAR) r_cnt <= r_cnt + 1'b1;
            if (r_state == SV_ICHECK && r_sq < SIZE_SQ && !spf_zero) r_i <= r_i + 1'b1;
            if (r_state == SV_JWRITE && j_sum >= SIZE_J) r_i <= r_i + 1'b1;
        end
    end

    // datapath: square of the current prime, walk pointer and cofactor
    always_ff @(posedge i_clk) begin
        if (r_state == SV_INEXT) r_sq <= (2*W)'(r_i) * (2*W)'(r_i);
        if (r_state == SV_ICHECK) begin
            r_j <= r_sq[W-1:0];
            r_k <= r_i;
        end
        if (r_state == SV_JWRITE) begin
            r_j <= j_sum[W-1:0];
            r_k <= r_k + 1'b1;
        end
    end

endmodule

`default_nettype wire

[src/pfc_query.sv]
`default_nettype none

module pfc_query #(
    parameter int TABLE_SIZE = pfc_pkg::TABLE_SIZE_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_fill_done,
    input  wire                                i_valid,
    input  wire [pfc_pkg::VALUE_W-1:0]         i_query_value,
    output logic                               o_stall,
    output logic                               o_valid,
    output logic [pfc_pkg::COUNT_W-1:0]        o_factor_count,
    output logic [pfc_pkg::VALUE_W-1:0]        o_smallest_factor,
    input  wire                                i_stall,
    input  wire [2*$clog2(TABLE_SIZE)-1:0]     i_rdata,
    output pfc_pkg::t_mem_ctl                  o_ctl,
    output logic [$clog2(TABLE_SIZE)-1:0]      o_addr
);
    import pfc_pkg::*;

    localparam int W = $clog2(TABLE_SIZE);

    t_query_state r_state, n_state;
    logic [W-1:0]       r_rest;
    logic [W-1:0]       r_first;
    logic               r_first_pend;
    logic [COUNT_W-1:0] r_count;
    logic               r_out_valid;

    logic               accept;
    logic               in_range;
    logic               more;
    logic               out_free;
    logic [W-1:0]       eff_spf;
    logic [W-1:0]       eff_cof;

    assign accept   = i_valid && !o_stall;
    assign in_range = (32'(i_query_value) < TABLE_SIZE);
    assign more     = (r_rest > W'(1));
    assign out_free = !r_out_valid || !i_stall;

    // an entry left at zero is a prime, 0 or 1: it is its own factor
    always_comb begin
        if (i_rdata[W-1:0] == '0) begin
            eff_spf = r_rest;
            eff_cof = W'(1);
        end else begin
            eff_spf = i_rdata[W-1:0];
            eff_cof = i_rdata[2*W-1:W];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            QY_IDLE:  if (accept) n_state = in_range ? QY_CHECK : QY_DONE;
            QY_CHECK: if (!more) n_state = QY_DONE;
            QY_DONE:  if (out_free) n_state = QY_IDLE;
            default:  n_state = QY_IDLE;
        endcase
    end

    always_comb begin
        o_stall = !(i_fill_done && r_state == QY_IDLE);
        o_ctl   = '0;
        o_addr  = eff_cof;
        unique case (r_state)
            QY_IDLE: begin
                o_ctl.rd = accept && in_range;
                o_addr   = W'(i_query_value);
            end
            QY_CHECK: o_ctl.rd = more;
            QY_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= QY_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == QY_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == QY_IDLE && accept) begin
            r_rest       <= W'(i_query_value);
            r_first      <= '0;
            r_first_pend <= 1'b1;
            r_count      <= '0;
        end
        if (r_state == QY_CHECK) begin
            r_first_pend <= 1'b0;
            if (r_first_pend) r_first <= eff_spf;
            if (more) begin
                r_count <= r_count + 1'b1;
                r_rest  <= eff_cof;
            end
        end
        if (r_state == QY_DONE && out_free) begin
            o_factor_count    <= r_count;
            o_smallest_factor <= VALUE_W'(r_first);
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

[src/prime_factor_count_unit.sv]
`default_nettype none

// Channel  | Signals                                   | Direction
// ---------+-------------------------------------------+----------
// query    | i_valid, o_stall, i_query_value           | in
// result   | o_valid, i_stall, o_factor_count,         | out
//          | o_smallest_factor                         |
//
// After reset the table is cleared, one entry a cycle, then the sieve runs; queries
// are stalled until both are done.
// With the output register free, a query's result is formed by one table read per
// factor, a last check and the output load. The next query is taken only once the
// result is loaded and the unit is back in idle; a value outside the table skips
// the reads. A stalled result holds while the next item walks.

module prime_factor_count_unit #(
    parameter int TABLE_SIZE = pfc_pkg::TABLE_SIZE_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_stall,
    input  wire [pfc_pkg::VALUE_W-1:0]       i_query_value,
    output logic                             o_valid,
    input  wire                              i_stall,
    output logic [pfc_pkg::COUNT_W-1:0]      o_factor_count,
    output logic [pfc_pkg::VALUE_W-1:0]      o_smallest_factor
);
    import pfc_pkg::*;

    localparam int W = $clog2(TABLE_SIZE);

    // each entry holds {cofactor, smallest factor}; zero means the index is
    // its own factor (primes, 0 and 1)
    t_mem_ctl       sv_ctl, qy_ctl, ram_ctl;
    logic [W-1:0]   sv_addr, qy_addr, ram_addr;
    logic [2*W-1:0] sv_wdata, ram_rdata;
    logic           fill_done;

    pfc_sieve #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_sieve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rdata (ram_rdata),
        .o_ctl   (sv_ctl),
        .o_addr  (sv_addr),
        .o_wdata (sv_wdata),
        .o_done  (fill_done)
    );

    pfc_query #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_query (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_fill_done       (fill_done),
        .i_valid           (i_valid),
        .i_query_value     (i_query_value),
        .o_stall           (o_stall),
        .o_valid           (o_valid),
        .o_factor_count    (o_factor_count),
        .o_smallest_factor (o_smallest_factor),
        .i_stall           (i_stall),
        .i_rdata           (ram_rdata),
        .o_ctl             (qy_ctl),
        .o_addr            (qy_addr)
    );

    // hand the table port to the sieve until the fill is done
    always_comb begin
        if (fill_done) begin
            ram_ctl  = qy_ctl;
            ram_addr = qy_addr;
        end else begin
            ram_ctl  = sv_ctl;
            ram_addr = sv_addr;
        end
    end

    pfc_ram #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_ctl   (ram_ctl),
        .i_addr  (ram_addr),
        .i_wdata (sv_wdata),
        .o_rdata (ram_rdata)
    );

endmodule

`default_nettype wire
